[hw/rtl/ray_convex_face_closest_hit_core_macros.svh]
// Assertion macros used by the closest-hit core RTL.
`ifndef RAY_CONVEX_FACE_CLOSEST_HIT_CORE_MACROS_SVH
`define RAY_CONVEX_FACE_CLOSEST_HIT_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RCF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RCF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/rcf_pkg.sv]
// Types and constants shared by the closest-hit core modules.
`default_nettype none
package rcf_pkg;

   localparam int T_FRAC_BITS = 16;            // fraction bits of t
   localparam int T_W         = 17;            // width of t fields and registers
   localparam int NRM_FRAC    = 14;            // fraction bits of normals
   localparam int AXES        = 3;
   localparam int REQ_W       = 192;
   localparam int RSP_W       = 136;
   localparam int CSR_IDX_W   = 3;
   localparam int CNT_W       = 5;
   localparam int NUM_W       = 54;            // plane terms, Q.30
   localparam int MA_W        = 34;            // multiplier operand a
   localparam int MB_W        = 26;            // multiplier operand b
   localparam int PROD_W      = MA_W + MB_W;
   localparam int BI_W        = 50;            // edge normal components
   localparam int SPLIT       = 25;            // low slice of edge normal
   localparam int ACC_W       = 88;            // edge test sum
   localparam int MUL_STEPS   = 6;             // products per header or edge pass
   localparam int PNT_STEPS   = 3;

   localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC_BITS;
   localparam logic [T_W-1:0] NO_HIT = T_ONE + T_W'(1);

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_VERTEX = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      RSN_OK    = 3'd0,
      RSN_BACK  = 3'd1,
      RSN_RANGE = 3'd2,
      RSN_FAR   = 3'd3,
      RSN_EDGE  = 3'd4
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_SPAN_X  = 3'd3,
      CSR_SPAN_Y  = 3'd4,
      CSR_SPAN_Z  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      opcode_type         op;
      logic [15:0]        face_tag;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] plane_offset;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               is_last;
   } item_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] span_x;
      logic signed [31:0] span_y;
      logic signed [31:0] span_z;
   } ray_type;

   typedef enum logic [3:0] {
      S_IDLE, S_HMUL, S_HCHK, S_HRNG, S_DIV, S_HCLS, S_PNT,
      S_VSTART, S_EPREP, S_EBI, S_EDOT, S_EDONE, S_VEND, S_VFIN
   } exec_state_type;

endpackage
`default_nettype wire

[hw/rtl/rcf_front.sv]
// Front end: accepts request items, drops unused opcodes, queues the rest.
`default_nettype none
module rcf_front import rcf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             req_tlast,
   output item_type              q_item,
   output logic                  q_avail,
   input  wire logic             q_pop
);

   localparam int QDEPTH = 2;

   item_type   q_mem_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   dec;
   logic       push, pop;

   always_comb begin
      dec.op           = opcode_type'(req_tuser);
      dec.face_tag     = req_tdata[15:0];
      dec.normal_x     = req_tdata[31:16];
      dec.normal_y     = req_tdata[47:32];
      dec.normal_z     = req_tdata[63:48];
      dec.plane_offset = req_tdata[95:64];
      dec.vert_x       = req_tdata[127:96];
      dec.vert_y       = req_tdata[159:128];
      dec.vert_z       = req_tdata[191:160];
      dec.is_last      = req_tlast;
   end

   assign req_tready = (count_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready && (dec.op != OP_NONE);
   assign q_avail    = (count_ff != 2'd0);
   assign pop        = q_pop && q_avail;
   assign q_item     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/rcf_exec.sv]
// Back end: sequencer with one shared multiplier for header, point and edge math.
`default_nettype none
`include "ray_convex_face_closest_hit_core_macros.svh"
module rcf_exec import rcf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ray_type          ray,
   input  wire item_type         q_item,
   input  wire logic             q_avail,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   exec_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   item_type           item_ff;
   logic [T_W-1:0]     closest_t_ff;
   logic [15:0]        cur_tag_ff;
   logic signed [15:0] nrm_ff [AXES];
   logic [T_W-1:0]     cand_t_ff;
   logic signed [31:0] pnt_ff [AXES];
   reason_type         reason_ff;
   logic signed [31:0] first_ff [AXES];
   logic signed [31:0] prev_ff [AXES];
   logic               have_prev_ff;
   logic               closing_ff;

   logic signed [NUM_W-1:0] appr_ff, sdot_ff, num_ff;
   logic [NUM_W-1:0]        a_ff, rem_ff;
   logic [T_W-1:0]          q_ff;

   logic signed [32:0]     t_ff [AXES];
   logic signed [32:0]     rel_ff [AXES];
   logic signed [BI_W-1:0] bi_ff [AXES];
   logic signed [ACC_W-1:0] acc_ff;

   logic signed [MA_W-1:0]   ma;
   logic signed [MB_W-1:0]   mb;
   logic signed [PROD_W-1:0] prod_ff;

   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic signed [31:0] start_a [AXES];
   logic signed [31:0] span_a [AXES];
   logic signed [31:0] vtx [AXES];
   logic signed [31:0] edge_a [AXES];
   logic signed [31:0] edge_b [AXES];

   logic [2:0] cidx, kidx;
   logic [1:0] ccomp;
   logic       appr_pos, rng_bad, q_far, edge_out, out_free, fin_go;
   reason_type fin_reason;
   logic [NUM_W-1:0] div_r;
   logic             div_ge;
   logic signed [PROD_W-1:0] pnt_sum;
   logic signed [31:0]       pnt_sat;

   assign start_a[0] = ray.start_x;
   assign start_a[1] = ray.start_y;
   assign start_a[2] = ray.start_z;
   assign span_a[0]  = ray.span_x;
   assign span_a[1]  = ray.span_y;
   assign span_a[2]  = ray.span_z;
   assign vtx[0]     = item_ff.vert_x;
   assign vtx[1]     = item_ff.vert_y;
   assign vtx[2]     = item_ff.vert_z;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         edge_a[i] = closing_ff ? vtx[i] : prev_ff[i];
         edge_b[i] = closing_ff ? first_ff[i] : vtx[i];
      end
   end

   assign cidx  = cnt_ff[2:0];
   assign kidx  = cidx - 3'd1;
   assign ccomp = (cidx < 3'(AXES)) ? cidx[1:0] : 2'(cidx - 3'(AXES));

   // status terms
   always_comb begin
      appr_pos   = !appr_ff[NUM_W-1];
      rng_bad    = (!num_ff[NUM_W-1] && num_ff != '0) || ((-num_ff) > $signed(a_ff));
      q_far      = (q_ff >= closest_t_ff);
      edge_out   = !acc_ff[ACC_W-1] && (acc_ff != '0);
      out_free   = !rsp_valid_ff || rsp_tready;
      fin_go     = (state_ff == S_VFIN) && out_free;
      fin_reason = (reason_ff == RSN_OK && cand_t_ff >= closest_t_ff) ? RSN_FAR : reason_ff;
      div_r      = (cnt_ff == '0) ? rem_ff : (rem_ff << 1);
      div_ge     = (div_r >= a_ff);
      pnt_sum    = PROD_W'(start_a[kidx[1:0]]) + (prod_ff >>> T_FRAC_BITS);
      if (pnt_sum[PROD_W-1:31] == '0 || pnt_sum[PROD_W-1:31] == '1) begin
         pnt_sat = pnt_sum[31:0];
      end else if (pnt_sum[PROD_W-1]) begin
         pnt_sat = 32'sh8000_0000;
      end else begin
         pnt_sat = 32'sh7fff_ffff;
      end
   end

   // outputs: queue pop and multiplier operands
   always_comb begin
      q_pop = (state_ff == S_IDLE) && q_avail;
      ma    = '0;
      mb    = '0;
      unique case (state_ff)
         S_HMUL: begin
            ma = (cidx < 3'(AXES)) ? MA_W'(span_a[ccomp]) : MA_W'(start_a[ccomp]);
            mb = MB_W'(nrm_ff[ccomp]);
         end
         S_PNT: begin
            ma = MA_W'(span_a[cidx[1:0]]);
            mb = MB_W'({1'b0, q_ff});
         end
         S_EBI: begin
            unique case (cidx)
               3'd0: begin ma = MA_W'(t_ff[1]); mb = MB_W'(nrm_ff[2]); end
               3'd1: begin ma = MA_W'(t_ff[2]); mb = MB_W'(nrm_ff[1]); end
               3'd2: begin ma = MA_W'(t_ff[2]); mb = MB_W'(nrm_ff[0]); end
               3'd3: begin ma = MA_W'(t_ff[0]); mb = MB_W'(nrm_ff[2]); end
               3'd4: begin ma = MA_W'(t_ff[0]); mb = MB_W'(nrm_ff[1]); end
               3'd5: begin ma = MA_W'(t_ff[1]); mb = MB_W'(nrm_ff[0]); end
               default: begin ma = '0; mb = '0; end
            endcase
         end
         S_EDOT: begin
            if (cidx < 3'(MUL_STEPS)) begin
               ma = MA_W'(rel_ff[cidx[2:1]]);
               // high slice carries the sign, low slice is unsigned
               mb = cidx[0] ? MB_W'($signed(bi_ff[cidx[2:1]][BI_W-1:SPLIT]))
                            : MB_W'({1'b0, bi_ff[cidx[2:1]][SPLIT-1:0]});
            end
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (q_avail) begin
               if (q_item.op == OP_HEADER) begin
                  state_in = S_HMUL;
               end else if (q_item.op == OP_VERTEX) begin
                  state_in = S_VSTART;
               end
            end
         end
         S_HMUL:   if (cnt_ff == CNT_W'(MUL_STEPS)) state_in = S_HCHK;
         S_HCHK:   state_in = appr_pos ? S_IDLE : S_HRNG;
         S_HRNG: begin
            cnt_in   = '0;
            state_in = rng_bad ? S_IDLE : S_DIV;
         end
         S_DIV:    if (cnt_ff == CNT_W'(T_FRAC_BITS)) state_in = S_HCLS;
         S_HCLS: begin
            cnt_in   = '0;
            state_in = q_far ? S_IDLE : S_PNT;
         end
         S_PNT:    if (cnt_ff == CNT_W'(PNT_STEPS)) state_in = S_IDLE;
         S_VSTART: state_in = (have_prev_ff && reason_ff == RSN_OK) ? S_EPREP : S_VEND;
         S_EPREP: begin
            cnt_in   = '0;
            state_in = S_EBI;
         end
         S_EBI: begin
            if (cnt_ff == CNT_W'(MUL_STEPS)) begin
               state_in = S_EDOT;
               cnt_in   = '0;
            end
         end
         S_EDOT:   if (cnt_ff == CNT_W'(MUL_STEPS)) state_in = S_EDONE;
         S_EDONE:  state_in = closing_ff ? S_VFIN : S_VEND;
         S_VEND: begin
            if (!item_ff.is_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = (reason_ff == RSN_OK) ? S_EPREP : S_VFIN;
            end
         end
         S_VFIN:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
   end

   // model-visible face state
   always_ff @(posedge clock) begin
      if (reset) begin
         closest_t_ff <= NO_HIT;
         cur_tag_ff   <= '0;
         cand_t_ff    <= '0;
         reason_ff    <= RSN_OK;
         have_prev_ff <= 1'b0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            nrm_ff[i] <= '0;
            pnt_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && !fin_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_avail && q_item.op == OP_HEADER) begin
                  cur_tag_ff   <= q_item.face_tag;
                  nrm_ff[0]    <= q_item.normal_x;
                  nrm_ff[1]    <= q_item.normal_y;
                  nrm_ff[2]    <= q_item.normal_z;
                  cand_t_ff    <= '0;
                  have_prev_ff <= 1'b0;
                  for (int i = 0; i < AXES; i++) begin
                     pnt_ff[i] <= '0;
                  end
               end else if (q_avail && q_item.op == OP_CLEAR) begin
                  closest_t_ff <= NO_HIT;
               end
            end
            S_HCHK:   if (appr_pos) reason_ff <= RSN_BACK;
            S_HRNG:   if (rng_bad) reason_ff <= RSN_RANGE;
            S_HCLS: begin
               cand_t_ff <= q_ff;
               reason_ff <= q_far ? RSN_FAR : RSN_OK;
            end
            S_PNT:    if (cnt_ff != '0) pnt_ff[kidx[1:0]] <= pnt_sat;
            S_VSTART: begin
               closing_ff <= 1'b0;
               if (!have_prev_ff) have_prev_ff <= 1'b1;
            end
            S_EDONE:  if (edge_out && reason_ff == RSN_OK) reason_ff <= RSN_EDGE;
            S_VEND:   closing_ff <= 1'b1;
            S_VFIN: begin
               if (out_free) begin
                  reason_ff    <= fin_reason;
                  have_prev_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  if (fin_reason == RSN_OK) closest_t_ff <= cand_t_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (q_avail) item_ff <= q_item;
            appr_ff <= '0;
            sdot_ff <= '0;
         end
         S_HMUL: begin
            if (cnt_ff != '0) begin
               if (kidx < 3'(AXES)) appr_ff <= appr_ff + prod_ff[NUM_W-1:0];
               else                 sdot_ff <= sdot_ff + prod_ff[NUM_W-1:0];
            end
         end
         S_HCHK: begin
            num_ff <= (NUM_W'(item_ff.plane_offset) <<< NRM_FRAC) - sdot_ff;
            a_ff   <= -appr_ff;
         end
         S_HRNG: begin
            rem_ff <= -num_ff;
            q_ff   <= '0;
         end
         S_DIV: begin
            rem_ff <= div_ge ? (div_r - a_ff) : div_r;
            q_ff   <= ((cnt_ff == '0) ? q_ff : (q_ff << 1)) | T_W'(div_ge);
         end
         S_VSTART: begin
            if (!have_prev_ff) begin
               for (int i = 0; i < AXES; i++) first_ff[i] <= vtx[i];
            end
         end
         S_EPREP: begin
            for (int i = 0; i < AXES; i++) begin
               t_ff[i]   <= 33'(edge_b[i]) - 33'(edge_a[i]);
               rel_ff[i] <= 33'(pnt_ff[i]) - 33'(edge_a[i]);
            end
            acc_ff <= '0;
         end
         S_EBI: begin
            if (cnt_ff != '0) begin
               if (!kidx[0]) bi_ff[kidx[2:1]] <= prod_ff[BI_W-1:0];
               else bi_ff[kidx[2:1]] <= bi_ff[kidx[2:1]] - prod_ff[BI_W-1:0];
            end
         end
         S_EDOT: begin
            if (cnt_ff != '0) begin
               if (!kidx[0]) acc_ff <= acc_ff + ACC_W'(prod_ff);
               else          acc_ff <= acc_ff + (ACC_W'(prod_ff) <<< SPLIT);
            end
         end
         S_VEND: begin
            for (int i = 0; i < AXES; i++) prev_ff[i] <= vtx[i];
         end
         S_VFIN: begin
            if (out_free) begin
               if (fin_reason == RSN_OK) begin
                  rsp_data_ff <= {3'b000, pnt_ff[2], pnt_ff[1], pnt_ff[0], cand_t_ff,
                                  fin_reason, 1'b1, cur_tag_ff};
               end else begin
                  rsp_data_ff <= {3'b000, 96'd0, T_W'(0), fin_reason, 1'b0, cur_tag_ff};
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RCF_ASSERT_NOW(a_div_rem, state_ff == S_DIV, rem_ff <= a_ff, "divider remainder above divisor")
   `RCF_ASSERT_NOW(a_q_bound, state_ff == S_HCLS, q_ff <= T_ONE, "quotient above one")
   `RCF_ASSERT_NEXT(a_best_upd, fin_go && fin_reason == RSN_OK, closest_t_ff == $past(cand_t_ff), "closest hit not taken")

endmodule
`default_nettype wire

[hw/rtl/ray_convex_face_closest_hit_core.sv]
// Top level: ray registers, front queue and back-end sequencer of the closest-hit core.
//
// channel  dir  handshake              payload
// req_     in   req_tvalid/req_tready  tdata fields, tuser opcode, tlast is_last
// rsp_     out  rsp_tvalid/rsp_tready  tdata verdict fields
// csr_     in   csr_valid/csr_ready    csr_index, csr_data (ray registers 0..5)
//
// Items run one at a time through a single shared 34x26 multiplier and a
// one-bit-per-cycle restoring divider. Header: 6 dot-product terms, 17 divide
// steps, 3 point terms. Vertex: an edge test against the previous vertex, if
// any, and on the last vertex a closing edge test and the response. Clear:
// resets the closest hit. Reset is synchronous and clears all control state
// and the closest hit; no clearing pass. A two-item queue lets the input keep
// taking items while the back end works or waits on rsp_tready.
`default_nettype none
module ray_convex_face_closest_hit_core import rcf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // face_tag, normal_x, normal_y, normal_z, plane_offset, vert_x, vert_y, vert_z
   input  wire logic [REQ_W-1:0]     req_tdata,
   // opcode
   input  wire logic [1:0]           req_tuser,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // out_tag, hit, reject_code, hit_t, hit_x, hit_y, hit_z, 3 zero pad bits
   output logic [RSP_W-1:0]          rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   ray_type  ray_ff;
   item_type q_item;
   logic     q_avail;
   logic     q_pop;

   // ray registers are always writable; indexes past the list are ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_X: ray_ff.start_x <= csr_data;
            CSR_START_Y: ray_ff.start_y <= csr_data;
            CSR_START_Z: ray_ff.start_z <= csr_data;
            CSR_SPAN_X:  ray_ff.span_x  <= csr_data;
            CSR_SPAN_Y:  ray_ff.span_y  <= csr_data;
            CSR_SPAN_Z:  ray_ff.span_z  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_item     (q_item),
      .q_avail    (q_avail),
      .q_pop      (q_pop)
   );

   rcf_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .ray        (ray_ff),
      .q_item     (q_item),
      .q_avail    (q_avail),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
